[rtl/ugam_pkg.sv]
// Shared types, constants and code point classifiers for the UTF-8 glyph advance meter.
package ugam_pkg;

  localparam int unsigned CP_W          = 21;
  localparam int unsigned ADV_W         = 6;
  localparam int unsigned LINE_TOTAL_W  = 16;
  localparam int unsigned TOTAL_BITS_DEF = 16;
  localparam int unsigned APB_ADDR_W    = 4;
  localparam int unsigned APB_DATA_W    = 32;
  localparam int unsigned PART_W        = 15;

  localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;
  localparam logic [CP_W-1:0] ASCII_SPACE = 21'h000020;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_FULLWIDTH = 2'd0;
  localparam logic [1:0] REG_SPACE     = 2'd1;
  localparam logic [1:0] REG_OTHER     = 2'd2;

  localparam logic [ADV_W-1:0] FULLWIDTH_ADV_RST = 6'd20;
  localparam logic [ADV_W-1:0] SPACE_ADV_RST     = 6'd7;
  localparam logic [ADV_W-1:0] OTHER_ADV_RST     = 6'd11;

  // What one input byte leaves for the emitter: a run of replacements and
  // then, optionally, one decoded code point.
  typedef struct packed {
    logic [2:0]      err_cnt;
    logic            has_point;
    logic [CP_W-1:0] point;
    logic            fullwidth;
    logic            opening;
    logic            closing;
    logic            last;
  } ugam_job_t;

  localparam logic [CP_W-1:0] FW_LO [13] = '{
    21'h01100, 21'h02E80, 21'h03041, 21'h03400, 21'h04E00, 21'h0A000, 21'h0AC00,
    21'h0F900, 21'h0FE30, 21'h0FF00, 21'h0FFE0, 21'h20000, 21'h30000
  };
  localparam logic [CP_W-1:0] FW_HI [13] = '{
    21'h0115F, 21'h0303E, 21'h033FF, 21'h04DBF, 21'h09FFF, 21'h0A4CF, 21'h0D7A3,
    21'h0FAFF, 21'h0FE4F, 21'h0FF60, 21'h0FFE6, 21'h2FFFD, 21'h3FFFD
  };

  localparam logic [CP_W-1:0] CLOSE_SET [27] = '{
    21'h03001, 21'h03002, 21'h0300D, 21'h0300F, 21'h03011, 21'h03015, 21'h03017,
    21'h03019, 21'h0301B, 21'h0FF01, 21'h0FF09, 21'h0FF0C, 21'h0FF1A, 21'h0FF1B,
    21'h0FF1F, 21'h0FF5D, 21'h00021, 21'h0002C, 21'h0002E, 21'h0003A, 21'h0003B,
    21'h0003F, 21'h00029, 21'h0005D, 21'h0007D, 21'h00022, 21'h00027
  };

  localparam logic [CP_W-1:0] OPEN_SET [14] = '{
    21'h0300C, 21'h0300E, 21'h03010, 21'h03014, 21'h03016, 21'h03018, 21'h0301A,
    21'h0FF08, 21'h0FF5B, 21'h00028, 21'h0005B, 21'h0007B, 21'h00027, 21'h00022
  };

  function automatic logic cp_is_fullwidth(logic [CP_W-1:0] cp);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 13; i++) begin
      if (cp >= FW_LO[i] && cp <= FW_HI[i]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic logic cp_is_opening(logic [CP_W-1:0] cp);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 14; i++) begin
      if (cp == OPEN_SET[i]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic logic cp_is_closing(logic [CP_W-1:0] cp);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 27; i++) begin
      if (cp == CLOSE_SET[i]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

[rtl/utf8_glyph_advance_meter.sv]
// Top level of the UTF-8 glyph advance meter: decoder, job register, emitter and registers.
//
// Input stream: one byte of UTF-8 text per word in s_axis_tdata, s_axis_tlast on the final
// byte of the text. Output stream: one word per code point or U+FFFD replacement, with the
// class flags in m_axis_tuser, the chosen advance and the saturating line total in
// m_axis_tdata, and m_axis_tlast on the last word caused by the final input byte.
// A byte is decoded as it is accepted into a job register; the emitter turns the job into
// words, one per cycle while the receiver takes them, into the output register. The first
// word of a byte thus passes the job register and then the output register. Plain text
// streams at one byte per cycle while the receiver takes every word; a byte that gives
// several words (a broken or truncated sequence, up to four) holds the job register until
// its last word is emitted. Lead and middle continuation bytes give no word and skip it.
// The APB port holds three 6-bit advances at byte addresses 0, 4 and 8; write them only
// while the block is idle. Reset closes any open sequence, clears the line total and
// loads the default advances 20, 7 and 11. When the receiver stalls the output word
// holds, the job register fills and then s_axis_tready drops; no word is lost.
module utf8_glyph_advance_meter
  import ugam_pkg::*;
#(
  parameter int unsigned TotalBits = TOTAL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,  // [7:0] byte_in
  input  logic                  s_axis_tlast,  // text_end
  // Output stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [47:0]           m_axis_tdata,  // [20:0] code_point, [26:21] advance,
                                               // [42:27] line_total, [47:43] zero
  output logic [3:0]            m_axis_tuser,  // [0] decode_error, [1] is_fullwidth,
                                               // [2] is_opening, [3] is_closing
  output logic                  m_axis_tlast,  // final_result
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Configuration registers.
  logic [ADV_W-1:0] fw_adv_q, space_adv_q, other_adv_q;
  logic             cfg_write;
  logic [1:0]       cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign cfg_index = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_adv_q    <= FULLWIDTH_ADV_RST;
      space_adv_q <= SPACE_ADV_RST;
      other_adv_q <= OTHER_ADV_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FULLWIDTH: fw_adv_q    <= pwdata[ADV_W-1:0];
        REG_SPACE:     space_adv_q <= pwdata[ADV_W-1:0];
        REG_OTHER:     other_adv_q <= pwdata[ADV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_FULLWIDTH: prdata = {{(APB_DATA_W-ADV_W){1'b0}}, fw_adv_q};
      REG_SPACE:     prdata = {{(APB_DATA_W-ADV_W){1'b0}}, space_adv_q};
      REG_OTHER:     prdata = {{(APB_DATA_W-ADV_W){1'b0}}, other_adv_q};
      default:       prdata = '0;
    endcase
  end

  // Decoder and job register.
  ugam_job_t dec_job;
  ugam_job_t job_q, job_d;
  logic      job_valid_q, job_valid_d;
  logic      in_accept;
  logic      out_free;
  logic      emit;
  logic      emit_err;
  logic      job_last_word;
  logic      job_done;

  assign in_accept = s_axis_tvalid & s_axis_tready;

  ugam_decoder u_decoder (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .accept_i (in_accept),
    .job_o    (dec_job)
  );

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign emit          = job_valid_q && out_free;
  assign emit_err      = (job_q.err_cnt != 3'd0);
  assign job_last_word = emit_err ? (job_q.err_cnt == 3'd1 && !job_q.has_point) : 1'b1;
  assign job_done      = emit && job_last_word;
  assign s_axis_tready = !job_valid_q || job_done;

  always_comb begin
    job_d       = job_q;
    job_valid_d = job_valid_q;
    if (job_done) begin
      job_valid_d = 1'b0;
    end else if (emit && emit_err) begin
      job_d.err_cnt = job_q.err_cnt - 3'd1;
    end
    // Bytes that give no word never occupy the job register.
    if (in_accept && (dec_job.err_cnt != 3'd0 || dec_job.has_point)) begin
      job_d       = dec_job;
      job_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  // Emitter: one word per cycle, while the output is free, into the output register.
  logic [CP_W-1:0]         res_cp;
  logic                    res_fw;
  logic [ADV_W-1:0]        res_adv;
  logic                    res_final;
  logic [TotalBits-1:0]    sum_q, sum_d;
  logic [TotalBits:0]      sum_wide;
  logic [TotalBits-1:0]    sum_sat;
  logic [TotalBits+LINE_TOTAL_W-1:0] sum_ext;

  assign res_cp    = emit_err ? REPLACEMENT : job_q.point;
  assign res_fw    = !emit_err && job_q.fullwidth;
  assign res_final = job_q.last && job_last_word;

  always_comb begin
    if (res_fw) begin
      res_adv = fw_adv_q;
    end else if (!emit_err && job_q.point == ASCII_SPACE) begin
      res_adv = space_adv_q;
    end else begin
      res_adv = other_adv_q;
    end
  end

  assign sum_wide = {1'b0, sum_q} + {{(TotalBits+1-ADV_W){1'b0}}, res_adv};
  assign sum_sat  = sum_wide[TotalBits] ? {TotalBits{1'b1}} : sum_wide[TotalBits-1:0];
  assign sum_ext  = {{LINE_TOTAL_W{1'b0}}, sum_sat};
  assign sum_d    = res_final ? '0 : sum_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
      sum_q         <= '0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
      sum_q         <= sum_d;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_axis_tdata <= {5'd0, sum_ext[LINE_TOTAL_W-1:0], res_adv, res_cp};
      m_axis_tuser <= {!emit_err && job_q.closing, !emit_err && job_q.opening,
                       res_fw, emit_err};
      m_axis_tlast <= res_final;
    end
  end

`ifndef ASSERT_OFF
  a_err_is_replacement: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[CP_W-1:0] == REPLACEMENT)
    else $error("decode error word without U+FFFD");

  a_job_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> (job_q.err_cnt != 3'd0 || job_q.has_point))
    else $error("job register holds a job with no word");

  a_job_err_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> job_q.err_cnt <= 3'd4)
    else $error("more than four replacements for one byte");

  a_job_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q && !out_free |=> job_valid_q && $stable(job_q))
    else $error("job changed while the output was stalled");
`endif

endmodule

[rtl/ugam_decoder.sv]
// UTF-8 sequence decoder: holds the open sequence and turns each byte into a job.
module ugam_decoder
  import ugam_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic [7:0] byte_i,
  input  logic      last_i,
  input  logic      accept_i,
  output ugam_job_t job_o
);

  logic [PART_W-1:0] part_q, part_d;
  logic [1:0]        need_q, need_d;
  logic [1:0]        held_q, held_d;
  logic              start_c;
  logic              is_cont;

  assign is_cont = (byte_i[7:6] == 2'b10);

  always_comb begin
    need_d          = need_q;
    held_d          = held_q;
    part_d          = part_q;
    start_c         = 1'b0;
    job_o.err_cnt   = 3'd0;
    job_o.has_point = 1'b0;
    job_o.point     = '0;
    job_o.last      = last_i;

    if (need_q == 2'd0) begin
      start_c = 1'b1;
    end else if (is_cont) begin
      held_d = held_q + 2'd1;
      need_d = need_q - 2'd1;
      if (need_q == 2'd1) begin
        job_o.has_point = 1'b1;
        job_o.point     = {part_q, byte_i[5:0]};
        part_d          = '0;
        held_d          = 2'd0;
      end else begin
        part_d = {part_q[PART_W-7:0], byte_i[5:0]};
      end
    end else begin
      // Broken sequence: replace the lead and every continuation held.
      job_o.err_cnt = 3'd1 + {1'b0, held_q};
      part_d        = '0;
      start_c       = 1'b1;
    end

    if (start_c) begin
      held_d = 2'd0;
      if (!byte_i[7]) begin
        job_o.has_point = 1'b1;
        job_o.point     = {13'd0, byte_i};
        need_d          = 2'd0;
      end else if (byte_i[7:5] == 3'b110) begin
        part_d = {10'd0, byte_i[4:0]};
        need_d = 2'd1;
      end else if (byte_i[7:4] == 4'b1110) begin
        part_d = {11'd0, byte_i[3:0]};
        need_d = 2'd2;
      end else if (byte_i[7:3] == 5'b11110) begin
        part_d = {12'd0, byte_i[2:0]};
        need_d = 2'd3;
      end else begin
        job_o.err_cnt = job_o.err_cnt + 3'd1;
        need_d        = 2'd0;
      end
    end

    if (last_i) begin
      // A sequence still open at the end of the text is truncated.
      if (need_d != 2'd0) begin
        job_o.err_cnt = job_o.err_cnt + 3'd1 + {1'b0, held_d};
      end
      need_d = 2'd0;
      held_d = 2'd0;
      part_d = '0;
    end

    job_o.fullwidth = cp_is_fullwidth(job_o.point);
    job_o.opening   = cp_is_opening(job_o.point);
    job_o.closing   = cp_is_closing(job_o.point);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q <= '0;
      need_q <= 2'd0;
      held_q <= 2'd0;
    end else if (accept_i) begin
      part_q <= part_d;
      need_q <= need_d;
      held_q <= held_d;
    end
  end

endmodule
